// ----- rtl/tmsf_pkg.sv -----
package tmsf_pkg;

  // field widths
  localparam int SAMPLE_W = 12;
  localparam int CFG_W    = 7;

  // default store size and reset count
  localparam int        MAX_SAMPLES_DEF = 64;
  localparam logic [6:0] COUNT_RESET    = 7'd21;

  // floor(n/5) as (n * 205) >> 10, exact for n below 1024
  localparam int TRIM_MUL   = 205;
  localparam int TRIM_SHIFT = 10;

  // operations of the shared add/subtract unit
  typedef enum logic [0:0] {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage

// ----- rtl/tmsf_ram.sv -----
module tmsf_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/tmsf_alu.sv -----
module tmsf_alu #(
  parameter int W = 19
) (
  input  tmsf_pkg::alu_op_t op,
  input  logic [W-1:0]      a,
  input  logic [W-1:0]      b,
  output logic [W-1:0]      y,
  output logic              borrow
);

  logic [W:0] full;

  // add or subtract, carry or borrow out on the top bit
  always_comb begin
    case (op)
      tmsf_pkg::ALU_SUB: full = {1'b0, a} - {1'b0, b};
      tmsf_pkg::ALU_ADD: full = {1'b0, a} + {1'b0, b};
      default:           full = {1'b0, a} + {1'b0, b};
    endcase
  end

  assign y      = full[W-1:0];
  assign borrow = full[W];

endmodule

// ----- rtl/trimmed_mean_sample_filter_core.sv -----
// channel | direction | handshake            | payload
// --------+-----------+----------------------+-----------------------------
// in      | input     | in_valid / in_ready  | sample [11:0]
// out     | output    | out_valid / out_ready| filtered_value [11:0]
// cfg     | input     | cfg_valid / cfg_ready| sample_count [6:0]
//
// one sample beat is inserted in order: each stored entry greater than it is
// read and moved up one slot through the single store port, then the beat is
// written in its place (at once when it lands in slot 0) and the fill is
// checked. a beat that completes a batch then sums the m kept samples, one
// store read each, runs the bit-per-cycle division over the SUM_W-bit sum
// and finally loads the output register.
// rst clears the sequencer, batch fill and output valid and sets the count
// register to COUNT_RESET; the sample store needs no clearing pass. a finished
// result blocks the next sample beat until the output register takes it, so a
// stalled previous result stalls the input too.

module trimmed_mean_sample_filter_core #(
  parameter int MAX_SAMPLES = tmsf_pkg::MAX_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [tmsf_pkg::SAMPLE_W-1:0]   sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tmsf_pkg::SAMPLE_W-1:0]   filtered_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tmsf_pkg::CFG_W-1:0]      sample_count
);

  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = tmsf_pkg::SAMPLE_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);
  localparam int CW     = (CNT_W > tmsf_pkg::CFG_W) ? CNT_W : tmsf_pkg::CFG_W;
  localparam int PROD_W = CNT_W + tmsf_pkg::TRIM_SHIFT;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_INS_RD  = 7'b0000010,
    ST_INS_CMP = 7'b0000100,
    ST_CHECK   = 7'b0001000,
    ST_SUM_RD  = 7'b0010000,
    ST_SUM_ADD = 7'b0100000,
    ST_DIV     = 7'b1000000
  } state_t;

  // result waiting for the output register is held in the quotient
  logic done_pending;

  state_t                        state;
  logic [CNT_W-1:0]              fill;
  logic [CNT_W-1:0]              pos;
  logic [tmsf_pkg::SAMPLE_W-1:0] held;
  logic [CNT_W-1:0]              idx;
  logic [CNT_W-1:0]              hi;
  logic [CNT_W-1:0]              m;
  logic [SUM_W-1:0]              acc;
  logic [SUM_W-1:0]              q;
  logic [CNT_W-1:0]              rem;
  logic [STEP_W-1:0]             step;
  logic [tmsf_pkg::CFG_W-1:0]    count_cfg;

  // store port signals
  logic                          ram_we;
  logic [ADDR_W-1:0]             ram_waddr;
  logic [tmsf_pkg::SAMPLE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]             ram_raddr;
  logic [tmsf_pkg::SAMPLE_W-1:0] ram_rdata;

  // shared unit signals
  tmsf_pkg::alu_op_t             alu_op;
  logic [SUM_W-1:0]              alu_a;
  logic [SUM_W-1:0]              alu_b;
  logic [SUM_W-1:0]              alu_y;
  logic                          alu_borrow;

  logic [CW-1:0]                 cfg_ext;
  logic [CW-1:0]                 eff_count;
  logic [PROD_W-1:0]             trim_prod;
  logic [PROD_W-1:0]             trim_wide;
  logic [CNT_W-1:0]              trim;
  logic [CNT_W:0]                div_trial;
  logic                          out_load;

  assign in_ready  = (state == ST_IDLE) && !done_pending;
  assign cfg_ready = 1'b1;
  assign out_load  = done_pending && (!out_valid || out_ready);

  // effective batch size: zero taken as one, clamped to the store size
  always_comb begin
    cfg_ext = CW'(count_cfg);
    if (count_cfg == '0) begin
      eff_count = CW'(1);
    end else if (cfg_ext > CW'(MAX_SAMPLES)) begin
      eff_count = CW'(MAX_SAMPLES);
    end else begin
      eff_count = cfg_ext;
    end
  end

  // samples trimmed from each end: floor(fill / 5)
  assign trim_prod = PROD_W'(fill) * PROD_W'(tmsf_pkg::TRIM_MUL);
  assign trim_wide = trim_prod >> tmsf_pkg::TRIM_SHIFT;
  assign trim      = trim_wide[CNT_W-1:0];

  // partial remainder with next dividend bit shifted in
  assign div_trial = {rem, q[SUM_W-1]};

  // operand selection for the shared unit
  always_comb begin
    case (state)
      ST_INS_CMP: begin
        alu_op = tmsf_pkg::ALU_SUB;
        alu_a  = SUM_W'(held);
        alu_b  = SUM_W'(ram_rdata);
      end
      ST_SUM_ADD: begin
        alu_op = tmsf_pkg::ALU_ADD;
        alu_a  = acc;
        alu_b  = SUM_W'(ram_rdata);
      end
      ST_DIV: begin
        alu_op = tmsf_pkg::ALU_SUB;
        alu_a  = SUM_W'(div_trial);
        alu_b  = SUM_W'(m);
      end
      default: begin
        alu_op = tmsf_pkg::ALU_ADD;
        alu_a  = '0;
        alu_b  = '0;
      end
    endcase
  end

  tmsf_alu #(
    .W (SUM_W)
  ) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos[ADDR_W-1:0];
    ram_wdata = held;
    ram_raddr = idx[ADDR_W-1:0];
    case (state)
      ST_INS_RD: begin
        ram_raddr = ADDR_W'(pos - CNT_W'(1));
        if (pos == '0) begin
          ram_we = 1'b1;
        end
      end
      ST_INS_CMP: begin
        ram_we = 1'b1;
        if (alu_borrow) begin
          ram_wdata = ram_rdata;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tmsf_ram #(
    .WIDTH (tmsf_pkg::SAMPLE_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= tmsf_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_cfg <= sample_count;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      done_pending <= 1'b0;
    end else begin
      if (out_load) begin
        done_pending <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid && !done_pending) begin
            held  <= sample;
            pos   <= fill;
            state <= ST_INS_RD;
          end
        end
        ST_INS_RD: begin
          if (pos == '0) begin
            fill  <= fill + CNT_W'(1);
            state <= ST_CHECK;
          end else begin
            state <= ST_INS_CMP;
          end
        end
        ST_INS_CMP: begin
          if (alu_borrow) begin
            pos   <= pos - CNT_W'(1);
            state <= ST_INS_RD;
          end else begin
            fill  <= fill + CNT_W'(1);
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (CW'(fill) >= eff_count) begin
            idx   <= trim;
            hi    <= fill - trim;
            m     <= fill - trim - trim;
            acc   <= '0;
            fill  <= '0;
            state <= ST_SUM_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SUM_RD: begin
          state <= ST_SUM_ADD;
        end
        ST_SUM_ADD: begin
          acc <= alu_y;
          idx <= idx + CNT_W'(1);
          if (idx + CNT_W'(1) == hi) begin
            q     <= alu_y;
            rem   <= '0;
            step  <= STEP_W'(SUM_W);
            state <= ST_DIV;
          end else begin
            state <= ST_SUM_RD;
          end
        end
        ST_DIV: begin
          rem  <= alu_borrow ? div_trial[CNT_W-1:0] : alu_y[CNT_W-1:0];
          q    <= {q[SUM_W-2:0], ~alu_borrow};
          step <= step - STEP_W'(1);
          if (step == STEP_W'(1)) begin
            done_pending <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_value <= q[tmsf_pkg::SAMPLE_W-1:0];
    end
  end

  // batch fill never passes the store size
  assert property (@(posedge clk) disable iff (rst)
    CW'(fill) <= CW'(MAX_SAMPLES))
    else $error("batch fill beyond store size");

  // remainder stays below the divisor while dividing
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < m))
    else $error("division remainder not below divisor");

  // summing walks only the kept part of the batch
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SUM_RD) |-> (idx < hi))
    else $error("sum index past kept range");

  // an accepted sample always starts an insertion
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_INS_RD))
    else $error("accepted beat did not start insertion");

  // a new result appears only after a finished division
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(done_pending))
    else $error("result shown without finished division");

endmodule
